>>> rtl/ucs_pkg.sv
package ucs_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    // register map, byte address = 4 * index
    localparam logic [APB_AW-3:0] REG_CHECK_MODE = 1'b0;

    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_VERIFY   = 1'b1;

    // packet byte positions of interest
    localparam logic [WORD_W-1:0] POS_PROTOCOL  = 16'd9;
    localparam logic [WORD_W-1:0] POS_SRC_IP    = 16'd12;
    localparam logic [WORD_W-1:0] POS_LEN_HI    = 16'd24;
    localparam logic [WORD_W-1:0] POS_LEN_LO    = 16'd25;
    localparam logic [WORD_W-1:0] POS_CSUM_HI   = 16'd26;
    localparam logic [WORD_W-1:0] POS_CSUM_LO   = 16'd27;
    localparam logic [WORD_W-1:0] POS_DATA      = 16'd28;
    localparam logic [WORD_W-1:0] POS_MAX       = 16'hFFFF;
    localparam logic [WORD_W:0]   IP_HDR_LEN    = 17'd20;
    localparam logic [WORD_W-1:0] UDP_HDR_LEN   = 16'd8;

    typedef struct packed {
        logic               last;
        logic [BYTE_W-1:0]  data;
    } t_byte_word;

    typedef struct packed {
        logic               length_error;
        logic               checksum_ok;
        logic [WORD_W-1:0]  checksum_value;
    } t_result;

    // 16-bit one's-complement add with end-around carry
    function automatic logic [WORD_W-1:0] ones_add(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        logic [WORD_W:0] s;
        logic [WORD_W:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
        return f[WORD_W-1:0];
    endfunction

endpackage

>>> rtl/ucs_in_stage.sv
module ucs_in_stage
    import ucs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_byte_word  i_word,
    input  logic        i_consume,
    output logic        o_ready,
    output logic        o_valid,
    output t_byte_word  o_word
);

    logic       r_valid;
    logic       n_valid;
    t_byte_word r_word;

    // free slot, or the held word leaves this cycle
    assign o_ready = !r_valid || i_consume;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    a_consume_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_consume |-> r_valid)
        else $error("consume without a held word");

endmodule

>>> rtl/ucs_accum.sv
module ucs_accum
    import ucs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_consume,
    input  t_byte_word  i_word,
    input  logic        i_check_mode,
    output t_result     o_result
);

    logic [WORD_W-1:0] r_sum;
    logic [WORD_W-1:0] r_pos;
    logic [BYTE_W-1:0] r_hold;
    logic [WORD_W-1:0] r_len;
    logic [WORD_W-1:0] n_sum;
    logic [WORD_W-1:0] n_pos;
    logic [WORD_W-1:0] n_len;

    logic              counted;
    logic [WORD_W-1:0] word16;
    logic [WORD_W-1:0] sum_a;
    logic [WORD_W:0]   end_pos;
    logic [WORD_W:0]   received;
    logic [WORD_W-1:0] csum;
    logic              in_csum_field;

    assign end_pos       = IP_HDR_LEN + {1'b0, r_len};
    assign in_csum_field = (r_pos == POS_CSUM_HI) || (r_pos == POS_CSUM_LO);

    always_comb begin
        counted = 1'b0;
        if (r_pos == POS_PROTOCOL) begin
            counted = 1'b1;
        end else if (r_pos >= POS_SRC_IP && r_pos <= POS_CSUM_LO) begin
            counted = !(i_check_mode == MODE_GENERATE && in_csum_field);
        end else if (r_pos >= POS_DATA && r_pos != POS_MAX
                     && {1'b0, r_pos} < end_pos) begin
            counted = 1'b1;
        end
    end

    // even position is the high half of a word
    assign word16 = r_pos[0] ? {{BYTE_W{1'b0}}, i_word.data}
                             : {i_word.data, {BYTE_W{1'b0}}};
    assign sum_a  = counted ? ones_add(r_sum, word16) : r_sum;

    always_comb begin
        n_len = r_len;
        n_sum = sum_a;
        if (r_pos == POS_LEN_LO) begin
            n_len = {r_hold, i_word.data};
            n_sum = ones_add(sum_a, n_len);
        end
    end

    assign n_pos    = (r_pos != POS_MAX) ? r_pos + 16'd1 : r_pos;
    assign received = {1'b0, r_pos} + 17'd1;
    assign csum     = ~n_sum;

    assign o_result.checksum_value = csum;
    assign o_result.checksum_ok    = (i_check_mode == MODE_VERIFY) && (csum == '0);
    assign o_result.length_error   = (n_len < UDP_HDR_LEN)
                                     || (received < IP_HDR_LEN + {1'b0, n_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_hold <= '0;
            r_len  <= '0;
        end else if (i_consume) begin
            if (i_word.last) begin
                r_sum  <= '0;
                r_pos  <= '0;
                r_hold <= '0;
                r_len  <= '0;
            end else begin
                r_sum <= n_sum;
                r_pos <= n_pos;
                r_len <= n_len;
                if (r_pos == POS_LEN_HI) begin
                    r_hold <= i_word.data;
                end
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_consume && i_word.last |=> r_pos == '0 && r_len == '0)
        else $error("packet state not cleared after last word");

    a_len_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != '0 |-> r_pos > POS_LEN_LO)
        else $error("udp length seen before byte 25");

endmodule

>>> rtl/udp_checksum_stream.sv
// udp checksum over an ipv4 packet streamed one byte per word, starting at ip header byte 0
// with a 20-byte ip header; the one's-complement sum covers the pseudo-header, udp header
// and data (odd data padded with zero), bytes past 20 + udp length are ignored, and on the
// word marked tlast one result word comes out with the complemented sum, a verify flag and
// a length error flag; check_mode (apb address 0, bit 0) selects generate (checksum field
// counted as zero) or verify; throughput is one byte per clock except while a final byte
// waits for a free result register; the input register holds a last byte, the result
// register its result; non-final bytes keep flowing while a result waits on the master side
module udp_checksum_stream
    import ucs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] packet_byte
    input  logic              s_axis_tlast,   // last_byte
    // result output
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // [15:0] checksum_value, [16] checksum_ok,
                                              // [17] length_error, [23:18] zero
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // configuration register
    logic r_check_mode;
    logic cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = paddr[APB_AW-1:2] == REG_CHECK_MODE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode <= MODE_GENERATE;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_check_mode <= pwdata[0];
        end
    end

    assign prdata = cfg_hit ? {{(APB_DW-1){1'b0}}, r_check_mode} : '0;

    // input register
    t_byte_word in_word;
    t_byte_word held_word;
    logic       held_valid;
    logic       consume;
    logic       out_free;
    logic       r_out_valid;

    assign in_word.data = s_axis_tdata;
    assign in_word.last = s_axis_tlast;

    // result register free this cycle, either empty or being drained
    assign out_free = !r_out_valid || m_axis_tready;
    // a final byte only moves when its result has somewhere to go
    assign consume  = held_valid && (!held_word.last || out_free);

    ucs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_word    (in_word),
        .i_consume (consume),
        .o_ready   (s_axis_tready),
        .o_valid   (held_valid),
        .o_word    (held_word)
    );

    // running sum and packet position
    t_result result;

    ucs_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_consume    (consume),
        .i_word       (held_word),
        .i_check_mode (r_check_mode),
        .o_result     (result)
    );

    // result register
    logic    n_out_valid;
    logic    load_out;
    t_result r_out;

    assign load_out = consume && held_word.last;

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.length_error, r_out.checksum_ok, r_out.checksum_value};

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out))
        else $error("pending result lost or changed");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result loaded over a pending one");

    a_ok_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.checksum_ok |-> r_out.checksum_value == '0)
        else $error("checksum_ok with nonzero checksum");

endmodule
